>>> hdl/sha512_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

    localparam int WORD_W      = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take_word;   // merge accepted word into the block buffer
        logic       start_block; // load working variables from the hash state
        logic       do_round;    // run one compression round
        logic       fold;        // add working variables into the hash state
        logic       pad_word;    // write one padding word at the fill position
        logic       init_hash;   // return to the initial hash values
        logic [3:0] emit_index;  // digest word to present
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       block_full;  // sixteen words are held
        logic       len_done;    // the length field has been written
        logic       round_done;  // the eightieth round is running
    } dp_status_t;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [6:0] LEN_FIELD_POS = 7'd112;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

>>> hdl/sha512_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// SHA-512 stream hasher. Each request carries up to eight message bytes, most
// significant first, with a byte count and a last flag. Words are merged into
// a 128-byte block buffer; when the block fills, the single shared round unit
// loads the working variables, runs 80 rounds and folds the result into the
// hash state, and no request is taken while it does so. A last request pads
// one word per cycle, except while a block is being hashed, and runs one or two
// padding blocks, then presents the eight digest words in order; the state then
// restarts for a new message.
module sha512_stream_hasher_core
    import sha512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // data_word[63:0], byte_count[67:64], zeros
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // digest_word[63:0], word_index[66:64], zeros
    output logic             m_axis_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy;
    logic       in_fire;
    logic       out_fire;
    logic [63:0] digest;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !busy;

    sha512_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_last  (s_axis_tlast),
        .out_fire (out_fire),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .out_valid(m_axis_tvalid)
    );

    sha512_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_word (s_axis_tdata[63:0]),
        .in_count(s_axis_tdata[67:64]),
        .status  (status),
        .digest  (digest)
    );

    assign m_axis_tdata = {5'd0, cmd.emit_index[2:0], digest};
    assign m_axis_tlast = (cmd.emit_index == 4'd7);

endmodule
`default_nettype wire

>>> hdl/sha512_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sha512_datapath
    import sha512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [63:0] in_word,
    input  wire logic [3:0]  in_count,
    output dp_status_t       status,
    output logic [63:0]      digest
);

    // Bytes are kept in a 128-byte window of 16 words, fill counted in bytes.
    logic [63:0] buf_reg [BLOCK_WORDS];
    logic [7:0]  fill_reg, fill_next;
    logic [63:0] msg_reg;
    logic [63:0] hash_reg [8];
    logic [63:0] v_reg [8];
    logic [6:0]  round_reg;
    logic [63:0] spill_reg;
    logic        mark_reg;
    logic        skip_reg;
    logic        len_reg;
    logic [3:0]  cnt;
    logic [127:0] merged;
    logic [63:0] wt, w2, w7, w15, w16, s0, s1, t1, t2;
    logic [63:0] bits;
    logic [63:0] pad_first;

    assign cnt = (in_count > 4'd8) ? 4'd8 : in_count;
    assign bits = msg_reg << 3;

    // The word straddles at most two buffer words; shift it into place.
    always_comb
    begin
        logic [127:0] win;
        logic [127:0] mask;
        logic [127:0] dat;
        logic [6:0]   sh;
        win  = {buf_reg[fill_reg[6:3]], buf_reg[fill_reg[6:3] + 4'd1]};
        sh   = {fill_reg[2:0], 3'b000};
        mask = ({64'hffffffffffffffff, 64'h0} << (7'd64 - {cnt, 3'b000})) >> sh;
        if (cnt == 4'd0)
        begin
            mask = '0;
        end
        dat    = {in_word, 64'h0} >> sh;
        merged = (win & ~mask) | (dat & mask);
    end

    // First pad word carries 0x80 after any partial bytes.
    assign pad_first = (buf_reg[fill_reg[6:3]]
                        & ~(64'hffffffffffffffff >> {fill_reg[2:0], 3'b000}))
                       | ({PAD_BYTE, 56'h0} >> {fill_reg[2:0], 3'b000});

    assign w2  = buf_reg[4'd14];
    assign w7  = buf_reg[4'd9];
    assign w15 = buf_reg[4'd1];
    assign w16 = buf_reg[4'd0];
    assign s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    assign s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    assign wt  = (round_reg < 7'd16) ? buf_reg[4'd0] : (s1 + w7 + s0 + w16);
    assign t1  = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
                 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                 + ROUND_K[round_reg] + wt;
    assign t2  = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
                 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.take_word)
        begin
            fill_next = fill_reg + {4'd0, cnt};
        end
        else if (cmd.pad_word)
        begin
            fill_next = {fill_reg[7:3] + 5'd1, 3'b000};
        end
        else if (cmd.start_block)
        begin
            fill_next = fill_reg - 8'd128;
        end
        else if (cmd.init_hash)
        begin
            fill_next = '0;
        end
    end

    assign status.block_full = fill_reg[7];
    assign status.len_done   = len_reg;
    assign status.round_done = (round_reg == 7'(ROUNDS - 1));
    assign digest = hash_reg[cmd.emit_index[2:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            msg_reg   <= '0;
            round_reg <= '0;
            mark_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            len_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= IV[i];
            end
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.take_word)
            begin
                msg_reg <= msg_reg + {60'd0, cnt};
                buf_reg[fill_reg[6:3]] <= merged[127:64];
                if (fill_reg[6:3] != 4'd15)
                begin
                    buf_reg[fill_reg[6:3] + 4'd1] <= merged[63:0];
                end
                else
                begin
                    spill_reg <= merged[63:0];
                end
            end
            if (cmd.pad_word)
            begin
                if (!mark_reg)
                begin
                    buf_reg[fill_reg[6:3]] <= pad_first;
                    mark_reg <= 1'b1;
                    // With 0x80 in the last two words the length goes in a second block.
                    if (fill_reg[6:3] >= 4'd14)
                    begin
                        skip_reg <= 1'b1;
                    end
                end
                else if ((fill_reg[6:3] == 4'd15) && !skip_reg)
                begin
                    buf_reg[4'd15] <= bits;
                    len_reg <= 1'b1;
                end
                else
                begin
                    buf_reg[fill_reg[6:3]] <= '0;
                end
            end
            if (cmd.start_block)
            begin
                round_reg <= '0;
                skip_reg  <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
            end
            if (cmd.do_round)
            begin
                round_reg <= round_reg + 7'd1;
                // Schedule window rotates by one word each round.
                for (int i = 0; i < 15; i++)
                begin
                    buf_reg[i] <= buf_reg[i + 1];
                end
                buf_reg[15] <= wt;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (cmd.fold)
            begin
                // Bytes that ran past the end of the block start the next one.
                buf_reg[4'd0] <= spill_reg;
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
            if (cmd.init_hash)
            begin
                msg_reg  <= '0;
                mark_reg <= 1'b0;
                len_reg  <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= IV[i];
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/sha512_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha512_ctrl
    import sha512_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic       in_last,
    input  wire logic       out_fire,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            out_valid
);

    ctrl_state_t state_reg, state_next;
    logic        final_reg, final_next;
    logic [3:0]  emit_reg, emit_next;

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        emit_next  = emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.block_full)
                begin
                    state_next = ST_ROUND;
                end
                else if (in_fire && in_last)
                begin
                    final_next = 1'b1;
                    state_next = ST_PAD;
                end
                else if (final_reg)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (status.round_done)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.len_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (status.block_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    emit_next = emit_reg + 4'd1;
                    if (emit_reg == 4'd7)
                    begin
                        emit_next  = '0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.emit_index = emit_reg;
        busy        = 1'b1;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy          = status.block_full || final_reg;
                cmd.take_word = in_fire;
                cmd.start_block = status.block_full;
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_PAD:
            begin
                cmd.pad_word    = !status.block_full;
                cmd.start_block = status.block_full;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.init_hash = out_fire && (emit_reg == 4'd7);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            emit_reg  <= emit_next;
        end
    end

endmodule
`default_nettype wire

>>> test/tb_sha512_stream_hasher_core.sv
`timescale 1ns / 1ps
module tb_sha512_stream_hasher_core;
    import sha512_pkg::*;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Hash model state.
    logic [63:0] hash_h [8];
    logic [7:0]  blk [128];
    int unsigned fill_pos;
    logic [63:0] msg_len;
    digest_t     digest_q [$];

    int    errors = 0;
    int    idle_cycles = 0;
    bit    hold_sink = 1'b0;
    int    hold_len = 0;
    bit    sink_bursty = 1'b1;
    bit    src_bursty = 1'b1;

    sha512_stream_hasher_core dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_blk();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = '0;
            for (int i = 0; i < 8; i++)
                w[t] = {w[t][55:0], blk[t * 8 + i]};
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                s1 = ror64(w[(t - 2) & 15], 19) ^ ror64(w[(t - 2) & 15], 61)
                     ^ (w[(t - 2) & 15] >> 6);
                s0 = ror64(w[(t - 15) & 15], 1) ^ ror64(w[(t - 15) & 15], 8)
                     ^ (w[(t - 15) & 15] >> 7);
                wt = s1 + w[(t - 7) & 15] + s0 + w[t & 15];
                w[t & 15] = wt;
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] += v[i];
    endtask

    task automatic append_byte(logic [7:0] b);
        blk[fill_pos] = b;
        fill_pos++;
        if (fill_pos == 128)
        begin
            compress_blk();
            fill_pos = 0;
        end
    endtask

    task automatic restart_msg();
        for (int i = 0; i < 8; i++)
            hash_h[i] = IV[i];
        fill_pos = 0;
        msg_len = '0;
    endtask

    task automatic predict_digest(logic [63:0] data, logic [3:0] cnt, logic lst);
        int unsigned n;
        logic [63:0] bits;
        digest_t d;
        n = (cnt > 8) ? 8 : cnt;
        for (int i = 0; i < n; i++)
            append_byte(data[63 - 8 * i -: 8]);
        msg_len += n;
        if (lst)
        begin
            bits = msg_len << 3;
            append_byte(PAD_BYTE);
            while (fill_pos != LEN_FIELD_POS)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(bits[63 - 8 * i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_h[i];
                d.word_index = i[2:0];
                d.last_word = (i == 7);
                digest_q.push_back(d);
            end
            restart_msg();
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, exp_v);
        errors++;
    endtask

    // Sends one request after a random gap when the source is bursty and updates the prediction on acceptance.
    task automatic send_request(logic [63:0] data, logic [3:0] cnt, logic lst);
        int gap;
        gap = src_bursty ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        s_axis_tdata = {4'b0, cnt, data};
        s_axis_tlast = lst;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_digest(data, cnt, lst);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (digest_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(int words, bit odd_counts);
        logic [3:0] c;
        for (int i = 0; i < words; i++)
        begin
            c = odd_counts ? 4'($urandom_range(0, 15)) : 4'd8;
            send_request(rand64(), c, i == words - 1);
        end
    endtask

    task automatic test_directed();
        // Empty message, then corner word values and every byte count.
        send_request(64'h0, 4'd0, 1'b1);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_request(64'h0, 4'd0, 1'b0);
        send_request(64'h6162_6300_0000_0000, 4'd3, 1'b1);
        for (int c = 0; c <= 15; c++)
            send_request(64'hA5A5_5A5A_F00F_0FF0 ^ c, c[3:0], c == 15);
        // Message that ends exactly where a second padding block is needed.
        for (int i = 0; i < 14; i++)
            send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, i == 13);
        send_request(64'h0123_4567_89AB_CDEF, 4'd8, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // Sink stalls for a long stretch while the source keeps pushing.
        hold_len = 400;
        hold_sink = 1'b1;
        src_bursty = 1'b0;
        for (int m = 0; m < 3; m++)
            send_message($urandom_range(1, 5), 1'b1);
        src_bursty = 1'b1;
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 150)
        begin
            int w;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
            sink_bursty = $urandom_range(0, 3) != 0;
            src_bursty = $urandom_range(0, 3) != 0;
            send_message(w, 1'($urandom_range(0, 1)));
            sent += w;
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Sink: random stalls, plus a long hold-off when asked.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_sink = 1'b0;
            end
            gap = sink_bursty ? $urandom_range(0, 17) : 0;
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    // Checker for each accepted digest word.
    always @(posedge clk)
    begin
        digest_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                report_mismatch("unexpected digest word", m_axis_tdata[63:0], '0);
            end
            else
            begin
                e = digest_q.pop_front();
                if (m_axis_tdata[63:0] !== e.digest_word)
                    report_mismatch("digest_word", m_axis_tdata[63:0], e.digest_word);
                if (m_axis_tdata[66:64] !== e.word_index)
                    report_mismatch("word_index", m_axis_tdata[66:64], e.word_index);
                if (m_axis_tlast !== e.last_word)
                    report_mismatch("last_word", m_axis_tlast, e.last_word);
                if (m_axis_tdata[71:67] !== '0)
                    report_mismatch("pad bits", m_axis_tdata[71:67], '0);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        restart_msg();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        repeat (200) @(posedge clk);
        if (errors == 0 && digest_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
